// ----- hdl/ttpd_pkg.sv -----
// shared types, constants and step table of the two-tone page decoder
`timescale 1ns / 1ps
`default_nettype none

package ttpd_pkg;

   // field and register widths
   localparam int SAMPLE_W    = 16;
   localparam int COEFF_W     = 24;
   localparam int ST_W        = 48;
   localparam int MAG_W       = 25;
   localparam int BLK_W       = 9;
   localparam int THR_W       = 25;
   localparam int MS_W        = 16;
   localparam int BMS_W       = 8;
   localparam int DELTA_W     = 26;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 25;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 56;

   // result item layout
   localparam int RSP_MAG_A_LSB = 0;
   localparam int RSP_MAG_B_LSB = 25;
   localparam int RSP_SEEN_A    = 50;
   localparam int RSP_SEEN_B    = 51;
   localparam int RSP_PAGE      = 52;

   // energy datapath
   localparam int DIG_W  = 24;
   localparam int PROD_W = 48;
   localparam int T_W    = 72;
   localparam int ACC_W  = 124;
   localparam int SQ_W   = 50;
   localparam int SHF_W  = 7;
   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   // register reset values
   localparam logic signed [COEFF_W-1:0] COEFF_A_RST = 24'sd7133781;
   localparam logic signed [COEFF_W-1:0] COEFF_B_RST = 24'sd7908482;
   localparam logic [BLK_W-1:0]          BLOCK_LENGTH_RST = 9'd499;
   localparam logic [THR_W-1:0]          LEVEL_THRESHOLD_RST = 25'd1638400;
   localparam logic [MS_W-1:0]           TONE_A_MS_RST = 16'd1000;
   localparam logic [MS_W-1:0]           TONE_B_MS_RST = 16'd3000;
   localparam logic [BMS_W-1:0]          BLOCK_MS_RST = 8'd62;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COEFF_A         = 3'd0,
      CSR_COEFF_B         = 3'd1,
      CSR_BLOCK_LENGTH    = 3'd2,
      CSR_LEVEL_THRESHOLD = 3'd3,
      CSR_TONE_A_MS       = 3'd4,
      CSR_TONE_B_MS       = 3'd5,
      CSR_BLOCK_MS        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COEFF_W-1:0] coeff_a;
      logic signed [COEFF_W-1:0] coeff_b;
      logic [BLK_W-1:0]          block_length;
      logic [THR_W-1:0]          level_threshold;
      logic [MS_W-1:0]           tone_a_ms;
      logic [MS_W-1:0]           tone_b_ms;
      logic [BMS_W-1:0]          block_ms;
   } cfg_type;

   // both bin states at the end of a block
   typedef struct packed {
      logic signed [ST_W-1:0] pa;
      logic signed [ST_W-1:0] p2a;
      logic signed [ST_W-1:0] pb;
      logic signed [ST_W-1:0] p2b;
   } snap_type;

   typedef enum logic [2:0] {
      F_IDLE, F_MUL_AL, F_UPD_A, F_MUL_BL, F_UPD_B
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_MAC, B_PREP, B_SQRT, B_RING, B_RUN, B_SEEN, B_OUT
   } back_state_type;

   typedef enum logic [2:0] {
      OP_CM, OP_A0, OP_A1, OP_B0, OP_B1, OP_T0, OP_T1, OP_T2
   } opnd_type;

   typedef enum logic [1:0] {
      MK_NONE, MK_T, MK_CROSS, MK_SQ
   } mac_kind_type;

   typedef struct packed {
      opnd_type     xsel;
      opnd_type     ysel;
      logic [SHF_W-1:0] shift;
      mac_kind_type kind;
   } mac_op_type;

   // partial product schedule for one bin energy, scaled by 2^22:
   // t = |c|*|p1|, then t*|p2|, then the two squares
   function automatic mac_op_type mac_op(input logic [3:0] step);
      mac_op_type op;
      op = '{xsel: OP_CM, ysel: OP_A0, shift: 7'd0, kind: MK_NONE};
      case (step)
         4'd0:  op = '{xsel: OP_CM, ysel: OP_A0, shift: 7'd0,  kind: MK_T};
         4'd1:  op = '{xsel: OP_CM, ysel: OP_A1, shift: 7'd24, kind: MK_T};
         4'd2:  op = '{xsel: OP_T0, ysel: OP_B0, shift: 7'd0,  kind: MK_CROSS};
         4'd3:  op = '{xsel: OP_T0, ysel: OP_B1, shift: 7'd24, kind: MK_CROSS};
         4'd4:  op = '{xsel: OP_T1, ysel: OP_B0, shift: 7'd24, kind: MK_CROSS};
         4'd5:  op = '{xsel: OP_T1, ysel: OP_B1, shift: 7'd48, kind: MK_CROSS};
         4'd6:  op = '{xsel: OP_T2, ysel: OP_B0, shift: 7'd48, kind: MK_CROSS};
         4'd7:  op = '{xsel: OP_T2, ysel: OP_B1, shift: 7'd72, kind: MK_CROSS};
         4'd8:  op = '{xsel: OP_A0, ysel: OP_A0, shift: 7'd22, kind: MK_SQ};
         4'd9:  op = '{xsel: OP_A0, ysel: OP_A1, shift: 7'd47, kind: MK_SQ};
         4'd10: op = '{xsel: OP_A1, ysel: OP_A1, shift: 7'd70, kind: MK_SQ};
         4'd11: op = '{xsel: OP_B0, ysel: OP_B0, shift: 7'd22, kind: MK_SQ};
         4'd12: op = '{xsel: OP_B0, ysel: OP_B1, shift: 7'd47, kind: MK_SQ};
         4'd13: op = '{xsel: OP_B1, ysel: OP_B1, shift: 7'd70, kind: MK_SQ};
         default: op = '{xsel: OP_CM, ysel: OP_A0, shift: 7'd0, kind: MK_NONE};
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ttpd_front.sv -----
// front end: takes samples and runs both goertzel recursions
`timescale 1ns / 1ps
`default_nettype none

module ttpd_front #(
   parameter int BLOCK_MAX = 511
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ttpd_pkg::cfg_type               cfg,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [ttpd_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output ttpd_pkg::snap_type                   q_data
);
   import ttpd_pkg::*;

   localparam int IDX_W = $clog2(BLOCK_MAX + 1);
   localparam int CMP_W = ((IDX_W > BLK_W) ? IDX_W : BLK_W) + 1;
   localparam int UPD_W = ST_W + 6;
   localparam logic signed [UPD_W-1:0] ST_MAX = (UPD_W'(1) <<< (ST_W - 1)) - UPD_W'(1);
   localparam logic signed [UPD_W-1:0] ST_MIN = -(UPD_W'(1) <<< (ST_W - 1));

   front_state_type state_ff, state_in;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [ST_W-1:0]     pa_ff, p2a_ff, pb_ff, p2b_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic signed [48:0]         hp_ff, lp_ff;

   logic signed [COEFF_W-1:0]  mc;
   logic signed [24:0]         mop;
   logic signed [48:0]         mprod;
   logic signed [ST_W-1:0]     up_p2, upd;
   logic signed [73:0]         full;
   logic signed [UPD_W-1:0]    s;
   logic [CMP_W-1:0]           len, blk, next_idx;
   logic                       accept, blk_end;

   assign accept = req_tvalid && req_tready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_tready = !q_full;
            if (req_tvalid && !q_full) state_in = F_MUL_AL;
         end
         F_MUL_AL: state_in = F_UPD_A;
         F_UPD_A:  state_in = F_MUL_BL;
         F_MUL_BL: state_in = F_UPD_B;
         F_UPD_B:  state_in = F_IDLE;
         default:  state_in = F_IDLE;
      endcase
   end

   // shared multiplier: coefficient by signed upper or unsigned lower half of the last state
   always_comb begin
      case (state_ff)
         F_IDLE:   begin mc = cfg.coeff_a; mop = {pa_ff[47], pa_ff[47:24]}; end
         F_MUL_AL: begin mc = cfg.coeff_a; mop = {1'b0, pa_ff[23:0]}; end
         F_UPD_A:  begin mc = cfg.coeff_b; mop = {pb_ff[47], pb_ff[47:24]}; end
         F_MUL_BL: begin mc = cfg.coeff_b; mop = {1'b0, pb_ff[23:0]}; end
         default:  begin mc = cfg.coeff_b; mop = {1'b0, pb_ff[23:0]}; end
      endcase
      mprod = mc * mop;
   end

   // rounded product minus older state plus sample, saturated
   always_comb begin
      up_p2 = (state_ff == F_UPD_A) ? p2a_ff : p2b_ff;
      full  = {hp_ff[48], hp_ff, 24'b0} + 74'(lp_ff) + 74'sd2097152;
      s     = UPD_W'($signed(full[73:22])) - UPD_W'(up_p2) + UPD_W'(x_ff);
      if (s > ST_MAX) begin
         upd = ST_MAX[ST_W-1:0];
      end else if (s < ST_MIN) begin
         upd = ST_MIN[ST_W-1:0];
      end else begin
         upd = s[ST_W-1:0];
      end
   end

   // effective block length and block end
   always_comb begin
      blk = CMP_W'(cfg.block_length);
      if (blk == '0) begin
         len = CMP_W'(1);
      end else if (blk > CMP_W'(BLOCK_MAX)) begin
         len = CMP_W'(BLOCK_MAX);
      end else begin
         len = blk;
      end
      next_idx = CMP_W'(idx_ff) + CMP_W'(1);
      blk_end  = next_idx >= len;
   end

   assign q_push = (state_ff == F_UPD_B) && blk_end;
   assign q_data = '{pa: pa_ff, p2a: p2a_ff, pb: upd, p2b: pb_ff};

   // products and sample
   always_ff @(posedge clock) begin
      if (accept) x_ff <= req_tdata[SAMPLE_W-1:0];
      if (state_ff == F_IDLE || state_ff == F_UPD_A) hp_ff <= mprod;
      if (state_ff == F_MUL_AL || state_ff == F_MUL_BL) lp_ff <= mprod;
   end

   // recursion state and sample count
   always_ff @(posedge clock) begin
      if (reset) begin
         pa_ff  <= '0;
         p2a_ff <= '0;
         pb_ff  <= '0;
         p2b_ff <= '0;
         idx_ff <= '0;
      end else if (state_ff == F_UPD_A) begin
         pa_ff  <= upd;
         p2a_ff <= pa_ff;
      end else if (state_ff == F_UPD_B) begin
         if (blk_end) begin
            pa_ff  <= '0;
            p2a_ff <= '0;
            pb_ff  <= '0;
            p2b_ff <= '0;
            idx_ff <= '0;
         end else begin
            pb_ff  <= upd;
            p2b_ff <= pb_ff;
            idx_ff <= next_idx[IDX_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ttpd_fifo.sv -----
// two-entry queue of finished block states between front and back
`timescale 1ns / 1ps
`default_nettype none

module ttpd_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ttpd_pkg::snap_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output ttpd_pkg::snap_type     pop_data,
   output logic                   empty
);
   import ttpd_pkg::*;

   snap_type   mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ttpd_back.sv -----
// back end: bin energies, square roots, averaging and duration decisions
`timescale 1ns / 1ps
`default_nettype none

module ttpd_back #(
   parameter int AVG_LEN   = 5,
   parameter int RUN_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ttpd_pkg::cfg_type                cfg,
   input  wire logic                             q_empty,
   input  wire ttpd_pkg::snap_type               q_data,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [ttpd_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);
   import ttpd_pkg::*;

   localparam int PTR_W  = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
   localparam int SUM_W  = DELTA_W + $clog2(AVG_LEN + 1);
   localparam int LIM_W  = THR_W + $clog2(AVG_LEN + 1);
   localparam int CMP_W  = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 1;
   localparam int RP_W   = RUN_WIDTH + BMS_W;
   localparam int LONG_W = RUN_WIDTH + BMS_W + 4;
   localparam logic [3:0] MAC_LAST = 4'd14;

   back_state_type state_ff, state_in;
   snap_type       snap_ff;
   logic           bin_ff;
   logic [3:0]     cnt_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [T_W-1:0]    t_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [SQ_W-1:0]   rem_ff;
   logic [SQ_W:0]     res_ff;
   logic [4:0]        k_ff;
   logic              sat_ff;
   logic [MAG_W-1:0]  mag_a_ff, mag_b_ff;
   logic signed [DELTA_W-1:0] ring_ff [AVG_LEN];
   logic [PTR_W-1:0]  ptr_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [RUN_WIDTH-1:0] run_a_ff, run_b_ff;
   logic              base_ff, seen_a_ff, seen_b_ff;
   logic              out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;

   logic signed [ST_W-1:0]    p1, p2;
   logic signed [COEFF_W-1:0] c;
   logic [ST_W-1:0]    a, b;
   logic [COEFF_W-1:0] cm;
   logic               neg_cross;
   mac_op_type         op_cur, op_prev;
   logic [DIG_W-1:0]   opx, opy;
   logic [ACC_W-1:0]   shifted;
   logic [ACC_W-23:0]  e;
   logic [SQ_W:0]      bitv, trial, res_in;
   logic [MAG_W-1:0]   mag;
   logic signed [DELTA_W-1:0] delta;
   logic [SUM_W-1:0]   abs_sum;
   logic [CMP_W-1:0]   lim;
   logic               base, load, long_a, long_b;
   logic [RP_W-1:0]    rp_a, rp_b;

   function automatic logic [DIG_W-1:0] pick(input opnd_type s, input logic [ST_W-1:0] av,
                                            input logic [ST_W-1:0] bv,
                                            input logic [T_W-1:0] tv,
                                            input logic [COEFF_W-1:0] cv);
      logic [DIG_W-1:0] d;
      case (s)
         OP_CM:   d = cv;
         OP_A0:   d = av[23:0];
         OP_A1:   d = av[47:24];
         OP_B0:   d = bv[23:0];
         OP_B1:   d = bv[47:24];
         OP_T0:   d = tv[23:0];
         OP_T1:   d = tv[47:24];
         OP_T2:   d = tv[71:48];
         default: d = '0;
      endcase
      return d;
   endfunction

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign load = (state_ff == B_OUT) && (!out_valid_ff || rsp_tready);

   // next state and queue pop
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = B_MAC;
            end
         end
         B_MAC:  if (cnt_ff == MAC_LAST) state_in = B_PREP;
         B_PREP: state_in = B_SQRT;
         B_SQRT: if (k_ff == 5'd0) state_in = bin_ff ? B_RING : B_MAC;
         B_RING: state_in = B_RUN;
         B_RUN:  state_in = B_SEEN;
         B_SEEN: state_in = B_OUT;
         B_OUT:  if (load) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // operand magnitudes of the current bin
   always_comb begin
      p1 = bin_ff ? snap_ff.pb : snap_ff.pa;
      p2 = bin_ff ? snap_ff.p2b : snap_ff.p2a;
      c  = bin_ff ? cfg.coeff_b : cfg.coeff_a;
      a  = p1[ST_W-1] ? ST_W'(-p1) : p1;
      b  = p2[ST_W-1] ? ST_W'(-p2) : p2;
      cm = c[COEFF_W-1] ? COEFF_W'(-c) : c;
      neg_cross = c[COEFF_W-1] ^ p1[ST_W-1] ^ p2[ST_W-1];
      op_cur  = mac_op(cnt_ff);
      op_prev = mac_op(4'(cnt_ff - 4'd1));
      opx = pick(op_cur.xsel, a, b, t_ff, cm);
      opy = pick(op_cur.ysel, a, b, t_ff, cm);
      shifted = ACC_W'(prod_ff) << op_prev.shift;
   end

   // multiply-accumulate of the scaled energy
   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE || (state_ff == B_SQRT && k_ff == 5'd0)) begin
         cnt_ff <= '0;
         t_ff   <= '0;
         acc_ff <= '0;
      end else if (state_ff == B_MAC) begin
         cnt_ff  <= cnt_ff + 4'd1;
         prod_ff <= opx * opy;
         case (op_prev.kind)
            MK_T:     t_ff <= t_ff + shifted[T_W-1:0];
            MK_CROSS: acc_ff <= neg_cross ? acc_ff + $signed(shifted)
                                          : acc_ff - $signed(shifted);
            MK_SQ:    acc_ff <= acc_ff + $signed(shifted);
            default:  acc_ff <= acc_ff;
         endcase
      end
   end

   // one root bit per step
   always_comb begin
      e      = acc_ff[ACC_W-1:22];
      bitv   = (SQ_W + 1)'(1) << {k_ff, 1'b0};
      trial  = res_ff + bitv;
      if ((SQ_W + 1)'(rem_ff) >= trial) begin
         res_in = (res_ff >> 1) + bitv;
      end else begin
         res_in = res_ff >> 1;
      end
      mag = sat_ff ? MAG_MAX : res_in[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_PREP) begin
         res_ff <= '0;
         k_ff   <= 5'd24;
         sat_ff <= 1'b0;
         if (acc_ff[ACC_W-1]) begin
            rem_ff <= '0;
         end else if (e[ACC_W-23:SQ_W] != '0) begin
            rem_ff <= '0;
            sat_ff <= 1'b1;
         end else begin
            rem_ff <= e[SQ_W-1:0];
         end
      end else if (state_ff == B_SQRT) begin
         res_ff <= res_in;
         k_ff   <= k_ff - 5'd1;
         if ((SQ_W + 1)'(rem_ff) >= trial) rem_ff <= rem_ff - trial[SQ_W-1:0];
         if (k_ff == 5'd0) begin
            if (bin_ff) mag_b_ff <= mag;
            else mag_a_ff <= mag;
         end
      end
   end

   // snapshot and bin select
   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && !q_empty) begin
         snap_ff <= q_data;
         bin_ff  <= 1'b0;
      end else if (state_ff == B_SQRT && k_ff == 5'd0) begin
         bin_ff <= 1'b1;
      end
   end

   // averaging, run counters and duration test
   always_comb begin
      delta   = DELTA_W'(mag_a_ff) - DELTA_W'(mag_b_ff);
      abs_sum = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : sum_ff;
      lim     = CMP_W'(cfg.level_threshold) * CMP_W'(AVG_LEN);
      base    = CMP_W'(abs_sum) < lim;
      rp_a    = RP_W'(run_a_ff) * RP_W'(cfg.block_ms);
      rp_b    = RP_W'(run_b_ff) * RP_W'(cfg.block_ms);
      long_a  = LONG_W'(rp_a) * LONG_W'(10) > LONG_W'(cfg.tone_a_ms) * LONG_W'(9);
      long_b  = LONG_W'(rp_b) * LONG_W'(10) > LONG_W'(cfg.tone_b_ms) * LONG_W'(9);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_LEN; i++) ring_ff[i] <= '0;
         ptr_ff    <= '0;
         sum_ff    <= '0;
         run_a_ff  <= '0;
         run_b_ff  <= '0;
         base_ff   <= 1'b0;
         seen_a_ff <= 1'b0;
         seen_b_ff <= 1'b0;
      end else begin
         case (state_ff)
            B_RING: begin
               ring_ff[ptr_ff] <= delta;
               sum_ff <= sum_ff + SUM_W'(delta) - SUM_W'(ring_ff[ptr_ff]);
               ptr_ff <= (ptr_ff == PTR_W'(AVG_LEN - 1)) ? '0 : ptr_ff + PTR_W'(1);
            end
            B_RUN: begin
               base_ff <= base;
               if (base) begin
                  run_a_ff <= '0;
                  run_b_ff <= '0;
               end else begin
                  if (!sum_ff[SUM_W-1] && sum_ff != '0 && run_a_ff != '1)
                     run_a_ff <= run_a_ff + RUN_WIDTH'(1);
                  if (sum_ff[SUM_W-1] && run_b_ff != '1)
                     run_b_ff <= run_b_ff + RUN_WIDTH'(1);
               end
            end
            B_SEEN: begin
               if (!base_ff) begin
                  if (long_a) seen_a_ff <= 1'b1;
                  else if (long_b) seen_b_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result item packing
   always_comb begin
      out_data_in = '0;
      out_data_in[RSP_MAG_A_LSB +: MAG_W] = mag_a_ff;
      out_data_in[RSP_MAG_B_LSB +: MAG_W] = mag_b_ff;
      out_data_in[RSP_SEEN_A] = seen_a_ff;
      out_data_in[RSP_SEEN_B] = seen_b_ff;
      out_data_in[RSP_PAGE]   = seen_a_ff && seen_b_ff;
   end

   always_ff @(posedge clock) begin
      if (load) out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

// ----- hdl/two_tone_page_decoder.sv -----
// top level of the two-tone page decoder: registers, front, queue and back
// each sample passes through the front states idle, mul_al, upd_a, mul_bl and upd_b (two bins, one shared multiplier)
// a block result follows its last sample through two bins of
// 15 multiply-accumulate steps and a 25-step square root, then the ring, run, seen and out states
// the back works on one block at a time; the front stalls when two blocks wait
// reset is synchronous and active high, loads register defaults and clears the control, recursion and averaging state
`timescale 1ns / 1ps
`default_nettype none

module two_tone_page_decoder #(
   parameter int AVG_LEN   = 5,
   parameter int BLOCK_MAX = 511,
   parameter int RUN_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // sample[15:0]
   input  wire logic [ttpd_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // mag_a[24:0], mag_b[49:25], tone_a_seen[50], tone_b_seen[51], page_found[52]
   output logic [ttpd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                             csr_wen,
   input  wire logic [ttpd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [ttpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ttpd_pkg::*;

   cfg_type  cfg_ff;
   snap_type q_in, q_out;
   logic     q_push, q_pop, q_full, q_empty;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coeff_a         <= COEFF_A_RST;
         cfg_ff.coeff_b         <= COEFF_B_RST;
         cfg_ff.block_length    <= BLOCK_LENGTH_RST;
         cfg_ff.level_threshold <= LEVEL_THRESHOLD_RST;
         cfg_ff.tone_a_ms       <= TONE_A_MS_RST;
         cfg_ff.tone_b_ms       <= TONE_B_MS_RST;
         cfg_ff.block_ms        <= BLOCK_MS_RST;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_COEFF_A:         cfg_ff.coeff_a <= csr_wdata[COEFF_W-1:0];
            CSR_COEFF_B:         cfg_ff.coeff_b <= csr_wdata[COEFF_W-1:0];
            CSR_BLOCK_LENGTH:    cfg_ff.block_length <= csr_wdata[BLK_W-1:0];
            CSR_LEVEL_THRESHOLD: cfg_ff.level_threshold <= csr_wdata[THR_W-1:0];
            CSR_TONE_A_MS:       cfg_ff.tone_a_ms <= csr_wdata[MS_W-1:0];
            CSR_TONE_B_MS:       cfg_ff.tone_b_ms <= csr_wdata[MS_W-1:0];
            CSR_BLOCK_MS:        cfg_ff.block_ms <= csr_wdata[BMS_W-1:0];
            default: ;
         endcase
      end
   end

   ttpd_front #(.BLOCK_MAX(BLOCK_MAX)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   ttpd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   ttpd_back #(.AVG_LEN(AVG_LEN), .RUN_WIDTH(RUN_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_data     (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- hdl/ttpd_checker.sv -----
// port-level checks of the two-tone page decoder and their binding
`timescale 1ns / 1ps
`default_nettype none

module ttpd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [ttpd_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ttpd_pkg::*;

   // a stalled result item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item dropped or changed while stalled");

   // page flag is the conjunction of both seen flags
   a_page: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_PAGE] == (rsp_tdata[RSP_SEEN_A] && rsp_tdata[RSP_SEEN_B]))
      else $error("page flag disagrees with seen flags");

   // no result item right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item valid after reset");

endmodule

bind two_tone_page_decoder ttpd_checker u_chk (.*);

`default_nettype wire
